// ===== hw/rtl/efcd_pkg.sv =====
// ----------------------------------------------------------------------------
// efcd_pkg
// Shared types, constants and the CRC-16/ARC byte update for the escaped
// frame deframer.
// ----------------------------------------------------------------------------
package efcd_pkg;

  // Frame size limit in stored (unstuffed) bytes, 4 .. 258
  localparam int MAX_FRAME_BYTES = 256;
  // Stored-byte counter holds up to MAX_FRAME_BYTES
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

  // Token queue between front and back, depth must be a power of two
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

  // Line codes
  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam logic [7:0] ESC_OK_LO   = 8'h5D;
  localparam logic [7:0] ESC_OK_HI   = 8'h5E;

  // Reflected polynomial; table entry 1 of this CRC is 16'hC0C1
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_INIT   = 16'h0000;

  // Classified item passed from front to back
  typedef enum logic [1:0] {
    TOK_DATA    = 2'd0,
    TOK_FLAG    = 2'd1,
    TOK_BAD_ESC = 2'd2
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  data;
  } token_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_DROP    = 2'd2
  } kind_t;

  // Drop reason
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_CRC      = 3'd2,
    ERR_BAD_ESC  = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_t;

  // One byte of CRC-16/ARC, bitwise over eight narrow steps
  function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/efcd_front.sv =====
// ----------------------------------------------------------------------------
// efcd_front
// Accepts line bytes, tracks the escape state and pushes classified tokens
// (data, delimiter, bad escape) into the token queue.
// ----------------------------------------------------------------------------
module efcd_front
  import efcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       q_full,
  output logic       q_push,
  output token_t     q_push_tok
);

  logic escape_r;
  logic escape_nxt;
  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the incoming byte
  always_comb begin
    escape_nxt      = escape_r;
    q_push          = 1'b0;
    q_push_tok.kind = TOK_DATA;
    q_push_tok.data = in_byte;
    if (accept) begin
      if (in_byte == FLAG_BYTE) begin
        // delimiter abandons any pending escape
        q_push          = 1'b1;
        q_push_tok.kind = TOK_FLAG;
        escape_nxt      = 1'b0;
      end else if (in_byte == ESC_BYTE) begin
        escape_nxt      = 1'b1;
      end else if (escape_r) begin
        q_push     = 1'b1;
        escape_nxt = 1'b0;
        if (in_byte == ESC_OK_LO || in_byte == ESC_OK_HI) begin
          q_push_tok.data = in_byte ^ ESC_XOR;
        end else begin
          q_push_tok.kind = TOK_BAD_ESC;
        end
      end else begin
        q_push = 1'b1;
      end
    end
  end

  // Escape state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r <= 1'b0;
    end else begin
      escape_r <= escape_nxt;
    end
  end

endmodule

// ===== hw/rtl/efcd_queue.sv =====
// ----------------------------------------------------------------------------
// efcd_queue
// Short token FIFO between front and back.
// ----------------------------------------------------------------------------
module efcd_queue
  import efcd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  token_t push_tok,
  output logic   full,
  input  logic   pop,
  output logic   pop_valid,
  output token_t pop_tok
);

  token_t              entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] fill_r;

  assign full      = (fill_r == QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid = (fill_r != '0);
  assign pop_tok   = entry_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_tok;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + QUEUE_CW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - QUEUE_CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/efcd_back.sv =====
// ----------------------------------------------------------------------------
// efcd_back
// Executes tokens: two-byte delay, CRC accumulation, size limit, frame
// check, and the registered result stage.
// ----------------------------------------------------------------------------
module efcd_back
  import efcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tok_valid,
  input  token_t     tok,
  output logic       tok_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_error_code,
  output logic [7:0] out_frame_length
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       older_r, older_nxt;
  logic [7:0]       newer_r, newer_nxt;

  logic             out_valid_r;
  kind_t            kind_r;
  logic [7:0]       data_r;
  err_t             err_r;
  logic [7:0]       len_r;

  logic             res_valid;
  kind_t            res_kind;
  logic [7:0]       res_data;
  err_t             res_err;
  logic [7:0]       res_len;

  logic [CNT_W-1:0] cnt_inc;
  logic             leaves;

  assign tok_pop = tok_valid && (!out_valid_r || out_ready);
  assign cnt_inc = count_r + CNT_W'(1);
  assign leaves  = (count_r >= CNT_W'(2));

  // Token execution
  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    res_valid = 1'b0;
    res_kind  = KIND_PAYLOAD;
    res_data  = 8'h00;
    res_err   = ERR_NONE;
    res_len   = 8'h00;
    unique case (tok.kind)
      TOK_FLAG: begin
        res_valid = 1'b1;
        if (!leaves) begin
          res_kind = KIND_DROP;
          res_err  = ERR_SHORT;
        end else if ({older_r, newer_r} == crc_r) begin
          res_kind = KIND_ACCEPT;
          res_len  = 8'(count_r - CNT_W'(2));
        end else begin
          res_kind = KIND_DROP;
          res_err  = ERR_CRC;
        end
        count_nxt = '0;
        crc_nxt   = CRC_INIT;
        older_nxt = 8'h00;
        newer_nxt = 8'h00;
      end
      TOK_BAD_ESC: begin
        res_valid = 1'b1;
        res_kind  = KIND_DROP;
        res_err   = ERR_BAD_ESC;
        count_nxt = '0;
        crc_nxt   = CRC_INIT;
        older_nxt = 8'h00;
        newer_nxt = 8'h00;
      end
      TOK_DATA: begin
        if (cnt_inc >= CNT_W'(MAX_FRAME_BYTES)) begin
          // size limit: drop replaces the byte leaving the delay
          res_valid = 1'b1;
          res_kind  = KIND_DROP;
          res_err   = ERR_OVERFLOW;
          count_nxt = '0;
          crc_nxt   = CRC_INIT;
          older_nxt = 8'h00;
          newer_nxt = 8'h00;
        end else begin
          if (leaves) begin
            crc_nxt   = crc_arc_byte(crc_r, older_r);
            res_valid = 1'b1;
            res_data  = older_r;
          end
          older_nxt = newer_r;
          newer_nxt = tok.data;
          count_nxt = cnt_inc;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= CRC_INIT;
      older_r <= 8'h00;
      newer_r <= 8'h00;
    end else if (tok_pop) begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      older_r <= older_nxt;
      newer_r <= newer_nxt;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tok_pop && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (tok_pop && res_valid) begin
      kind_r <= res_kind;
      data_r <= res_data;
      err_r  <= res_err;
      len_r  <= res_len;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_data_byte    = data_r;
  assign out_error_code   = err_r;
  assign out_frame_length = len_r;

endmodule

// ===== hw/rtl/escaped_frame_crc_deframer.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_crc_deframer
// Byte-stuffed frame deframer with CRC-16/ARC check: unstuffs line bytes,
// gives out payload bytes and reports frame accept or drop.
// ----------------------------------------------------------------------------
//
//  channel   ports                                   moves
//  input     in_valid / in_ready / in_byte           one stuffed line byte
//  output    out_valid / out_ready / out_kind,        payload byte, frame
//            out_data_byte, out_error_code,           accept or frame drop
//            out_frame_length
//
//  One byte per cycle sustained while the output is ready; a token goes
//  from the front into the token queue; the back registers its result.
//  The rate is set by the single CRC byte update in the back stage.
//  Synchronous active-low reset clears the escape state, queue, frame
//  state and result valid.
//  A stalled output holds the back stage; the queue absorbs two tokens
//  before in_ready drops.
//
module escaped_frame_crc_deframer
  import efcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_error_code,
  output logic [7:0] out_frame_length
);

  logic   q_full;
  logic   q_push;
  token_t q_push_tok;
  logic   q_pop;
  logic   q_pop_valid;
  token_t q_pop_tok;

  // Classification front
  efcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_tok (q_push_tok)
  );

  // Token queue
  efcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (q_push_tok),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_pop_valid),
    .pop_tok   (q_pop_tok)
  );

  // Frame execution back
  efcd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .tok_valid        (q_pop_valid),
    .tok              (q_pop_tok),
    .tok_pop          (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_error_code   (out_error_code),
    .out_frame_length (out_frame_length)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for escaped_frame_crc_deframer. A directed table walks the
// delimiter, escape, CRC and error corners, and then randomly built frames
// are sent: mostly well-formed and stuffed with a correct CRC-16/ARC, plus
// corrupted, truncated, badly escaped, oversized and noise frames. A local
// deframer model predicts all but the typed-in results. Results are compared
// field by field in order. Both sides idle at random, and the receiver holds
// off once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import efcd_pkg::*;

  localparam int RANDOM_ITEMS    = 1925;  // minimum line bytes in the random part
  localparam int HOLD_OFF_AT     = 400;   // transfers in before the long hold-off
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CALM_FROM       = 900;   // window with no idling on either side
  localparam int CALM_TO         = 1200;
  localparam int QUIET_LIMIT     = 3000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES    = 10;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    err_t        err;
    logic [7:0]  len;
  } frame_result_t;

  // How a directed row is checked
  typedef enum logic [1:0] {
    ROW_PREDICT,  // from the local model
    ROW_NONE,     // no result expected
    ROW_RESULT    // typed-in result
  } row_mode_t;

  typedef struct {
    logic [7:0]    line;
    row_mode_t     mode;
    frame_result_t res;
  } line_row_t;

  // DUT signals
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic [2:0] out_error_code;
  logic [7:0] out_frame_length;

  // Local deframer state
  bit          esc_pending;
  int          held_count;
  logic [15:0] frame_crc;
  logic [7:0]  held_old;
  logic [7:0]  held_new;
  logic [15:0] crc_lut [256];

  // Stimulus and expectations
  line_row_t     directed_rows[$];
  logic [7:0]    line_bytes[$];
  frame_result_t expected_results[$];

  // Bookkeeping
  int  in_count;
  int  out_count;
  int  errors;
  int  quiet_cycles;
  bit  holding;
  int  payload_seen;
  int  frames_good;
  int  drops_by_code [5];

  escaped_frame_crc_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_error_code   (out_error_code),
    .out_frame_length (out_frame_length)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model helpers
  // ---------------------------------------------------------------------------

  // Reflected CRC-16 lookup, built from the polynomial
  task automatic build_crc_lut();
    logic [15:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 16'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      crc_lut[i] = c;
    end
  endtask

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    return (crc >> 8) ^ crc_lut[crc[7:0] ^ b];
  endfunction

  task automatic clear_frame_state();
    esc_pending = 1'b0;
    held_count  = 0;
    frame_crc   = CRC_INIT;
    held_old    = 8'h00;
    held_new    = 8'h00;
  endtask

  // One line byte through the deframer; at most one result
  task automatic deframe_byte(input logic [7:0] b, output bit has_res,
                              output frame_result_t r);
    logic [7:0] d;
    logic [7:0] leaving;
    bit         leaves;
    int         plen;
    has_res = 1'b0;
    r       = '{KIND_PAYLOAD, 8'h00, ERR_NONE, 8'h00};
    if (b == FLAG_BYTE) begin
      has_res = 1'b1;
      r.kind  = KIND_DROP;
      if (held_count < 2) begin
        r.err = ERR_SHORT;
      end else if ({held_old, held_new} == frame_crc) begin
        plen   = held_count - 2;
        r.kind = KIND_ACCEPT;
        r.len  = plen[7:0];
      end else begin
        r.err = ERR_CRC;
      end
      clear_frame_state();
      return;
    end
    if (b == ESC_BYTE) begin
      esc_pending = 1'b1;
      return;
    end
    if (esc_pending) begin
      if (b != ESC_OK_LO && b != ESC_OK_HI) begin
        clear_frame_state();
        has_res = 1'b1;
        r.kind  = KIND_DROP;
        r.err   = ERR_BAD_ESC;
        return;
      end
      d           = b ^ ESC_XOR;
      esc_pending = 1'b0;
    end else begin
      d = b;
    end
    // two-byte delay; the byte that leaves feeds the CRC
    leaves  = (held_count >= 2);
    leaving = held_old;
    if (leaves) begin
      frame_crc = crc_next(frame_crc, leaving);
    end
    held_old   = held_new;
    held_new   = d;
    held_count = held_count + 1;
    if (held_count >= MAX_FRAME_BYTES) begin
      clear_frame_state();
      has_res = 1'b1;
      r.kind  = KIND_DROP;
      r.err   = ERR_OVERFLOW;
      return;
    end
    if (leaves) begin
      has_res = 1'b1;
      r.data  = leaving;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  task automatic add_row(input logic [7:0] line, input row_mode_t mode,
                         input kind_t kind = KIND_PAYLOAD, input logic [7:0] data = 8'h00,
                         input err_t err = ERR_NONE, input logic [7:0] len = 8'h00);
    line_row_t row;
    row.line = line;
    row.mode = mode;
    row.res  = '{kind, data, err, len};
    directed_rows.push_back(row);
  endtask

  // Payload bytes lean toward the line codes and the byte extremes
  function automatic logic [7:0] pick_payload_byte();
    logic [7:0] special [6];
    special = '{FLAG_BYTE, ESC_BYTE, ESC_OK_LO, ESC_OK_HI, 8'h00, 8'hFF};
    if ($urandom_range(0, 99) < 15) begin
      return special[$urandom_range(0, 5)];
    end
    return 8'($urandom);
  endfunction

  // Stuff one unstuffed byte onto the line
  task automatic stuff_byte(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      line_bytes.push_back(ESC_BYTE);
      line_bytes.push_back(b ^ ESC_XOR);
    end else begin
      line_bytes.push_back(b);
    end
  endtask

  // flavor: 0 good, 1 corrupted, 2 bad escape, 3 truncated, 4 noise
  task automatic build_frame(input int plen, input int flavor);
    logic [7:0]  body[$];
    logic [15:0] crc;
    int          pos;
    crc = CRC_INIT;
    if (flavor == 4) begin
      repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom));
      line_bytes.push_back(FLAG_BYTE);
      return;
    end
    for (int i = 0; i < plen; i++) begin
      body.push_back(pick_payload_byte());
      crc = crc_next(crc, body[i]);
    end
    body.push_back(crc[15:8]);
    body.push_back(crc[7:0]);
    if (flavor == 1) begin
      pos       = $urandom_range(0, body.size() - 1);
      body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    if (flavor == 3) begin
      pos = $urandom_range(0, body.size() - 1);
      while (body.size() > pos) void'(body.pop_back());
    end
    pos = (flavor == 2) ? $urandom_range(0, body.size()) : -1;
    for (int i = 0; i <= body.size(); i++) begin
      if (i == pos) begin
        line_bytes.push_back(ESC_BYTE);
        line_bytes.push_back(8'($urandom));
      end
      if (i < body.size()) stuff_byte(body[i]);
    end
    line_bytes.push_back(FLAG_BYTE);
  endtask

  task automatic build_random_part();
    int frame_no;
    int roll;
    int flavor;
    frame_no = 0;
    while (line_bytes.size() < RANDOM_ITEMS) begin
      roll   = $urandom_range(0, 99);
      flavor = (roll < 70) ? 0 : (roll < 78) ? 1 : (roll < 84) ? 2 : (roll < 90) ? 3 : 4;
      // a few long frames: largest accepted, exact overflow, far past the limit
      case (frame_no)
        3:       build_frame(MAX_FRAME_BYTES - 3, 0);
        12:      build_frame(MAX_FRAME_BYTES - 2, 0);
        25:      build_frame(MAX_FRAME_BYTES + 44, 0);
        default: build_frame($urandom_range(0, 24), flavor);
      endcase
      frame_no++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idling and driving
  // ---------------------------------------------------------------------------

  function automatic bit idle_roll();
    if (in_count >= CALM_FROM && in_count < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < 32;
  endfunction

  task automatic send_line(input logic [7:0] b);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // Receiver: random idling, or a long hold-off
  always @(posedge clk) begin
    if (holding) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_roll();
    end
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    wait (in_count >= HOLD_OFF_AT);
    holding <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // Input transfers feed the model
  always @(posedge clk) begin
    bit            has_res;
    frame_result_t r;
    if (rst_n && in_valid && in_ready) begin
      deframe_byte(in_byte, has_res, r);
      if (in_count < directed_rows.size() && directed_rows[in_count].mode != ROW_PREDICT) begin
        if (directed_rows[in_count].mode == ROW_RESULT) begin
          expected_results.push_back(directed_rows[in_count].res);
        end
      end else if (has_res) begin
        expected_results.push_back(r);
      end
      in_count <= in_count + 1;
    end
  end

  // Output transfers against the oldest expectation
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("result %0d with nothing expected: kind %0d", out_count,
                               out_kind));
      end else begin
        want = expected_results.pop_front();
        if (out_kind != want.kind)
          report_error($sformatf("result %0d kind %0d, want %0d", out_count, out_kind,
                                 want.kind));
        if (out_data_byte != want.data)
          report_error($sformatf("result %0d data 0x%02h, want 0x%02h", out_count,
                                 out_data_byte, want.data));
        if (out_error_code != want.err)
          report_error($sformatf("result %0d error code %0d, want %0d", out_count,
                                 out_error_code, want.err));
        if (out_frame_length != want.len)
          report_error($sformatf("result %0d frame length %0d, want %0d", out_count,
                                 out_frame_length, want.len));
      end
      case (kind_t'(out_kind))
        KIND_PAYLOAD: payload_seen++;
        KIND_ACCEPT:  frames_good++;
        default:      if (out_error_code < 5) drops_by_code[out_error_code]++;
      endcase
      out_count++;
    end
  end

  // Watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout after %0d cycles with no transfer", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    build_crc_lut();
    clear_frame_state();

    // delimiters on an empty or one-byte frame
    add_row(FLAG_BYTE, ROW_RESULT, KIND_DROP, 8'h00, ERR_SHORT);
    add_row(FLAG_BYTE, ROW_RESULT, KIND_DROP, 8'h00, ERR_SHORT);
    add_row(8'h00, ROW_NONE);
    add_row(FLAG_BYTE, ROW_RESULT, KIND_DROP, 8'h00, ERR_SHORT);
    // empty payload, CRC 0000
    add_row(8'h00, ROW_NONE);
    add_row(8'h00, ROW_NONE);
    add_row(FLAG_BYTE, ROW_RESULT, KIND_ACCEPT, 8'h00, ERR_NONE, 8'd0);
    // payload 01, CRC C0C1
    add_row(8'h01, ROW_NONE);
    add_row(8'hC0, ROW_NONE);
    add_row(8'hC1, ROW_RESULT, KIND_PAYLOAD, 8'h01);
    add_row(FLAG_BYTE, ROW_RESULT, KIND_ACCEPT, 8'h00, ERR_NONE, 8'd1);
    // escape while escaping, both escaped codes, then a delimiter mid-escape
    add_row(ESC_BYTE, ROW_NONE);
    add_row(ESC_BYTE, ROW_NONE);
    add_row(ESC_OK_HI, ROW_NONE);
    add_row(ESC_BYTE, ROW_NONE);
    add_row(ESC_OK_LO, ROW_NONE);
    add_row(8'hFF, ROW_RESULT, KIND_PAYLOAD, FLAG_BYTE);
    add_row(ESC_BYTE, ROW_PREDICT);
    add_row(FLAG_BYTE, ROW_PREDICT);
    // wrong CRC
    add_row(8'h00, ROW_NONE);
    add_row(8'h01, ROW_NONE);
    add_row(FLAG_BYTE, ROW_RESULT, KIND_DROP, 8'h00, ERR_CRC);
    // bad escape
    add_row(ESC_BYTE, ROW_NONE);
    add_row(8'h41, ROW_RESULT, KIND_DROP, 8'h00, ERR_BAD_ESC);

    build_random_part();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_line(directed_rows[i].line);
    foreach (line_bytes[i]) send_line(line_bytes[i]);
    in_valid <= 1'b0;
    @(posedge clk);

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_results.size()));
    end

    $display("Sent %0d line bytes; got %0d payload bytes and %0d good frames",
             in_count, payload_seen, frames_good);
    $display("Drops: short %0d, crc %0d, bad escape %0d, overflow %0d; mismatches %0d",
             drops_by_code[ERR_SHORT], drops_by_code[ERR_CRC], drops_by_code[ERR_BAD_ESC],
             drops_by_code[ERR_OVERFLOW], errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
